// ----- sv/lsc_pkg.sv -----
// ---------------------------------------------------------------------------
// lsc_pkg
// Shared types, codes and drive helpers of the lift sequence controller.
// ---------------------------------------------------------------------------
package lsc_pkg;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_DRIVE_DEADZONE      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BIN_DEADZONE        = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENCODER_SLACK       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_RAISE_TARGET        = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FORKLIFT_OPEN_BELOW = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_BOTTOM_WINDOW       = 3'd5;

    // Q2.14 drive levels
    localparam logic signed [15:0] Q_ONE         = 16'sd16384;
    localparam logic signed [15:0] Q_LOWER_STACK = -16'sd9830;
    localparam logic signed [15:0] Q_RAISE_BIN   = 16'sd13107;
    localparam logic signed [15:0] Q_LOWER_BIN   = -16'sd13107;

    typedef enum logic [1:0] {
        STACK_RAISE = 2'd0,
        STACK_LOWER = 2'd1,
        STACK_DONE  = 2'd2
    } stack_step_t;

    typedef enum logic [1:0] {
        BIN_RAISE = 2'd0,
        BIN_CLOSE = 2'd1,
        BIN_LOWER = 2'd2,
        BIN_DONE  = 2'd3
    } bin_step_t;

    typedef enum logic [1:0] {
        HUG_NONE  = 2'd0,
        HUG_OPEN  = 2'd1,
        HUG_CLOSE = 2'd2
    } hugger_t;

    typedef struct packed {
        logic [14:0] drive_deadzone;
        logic [14:0] bin_deadzone;
        logic [9:0]  encoder_slack;
        logic [14:0] raise_target;
        logic [14:0] forklift_open_below;
        logic [9:0]  bottom_window;
    } cfg_t;

    typedef struct packed {
        logic signed [15:0] manual_cmd;
        logic               stack_start;
        logic               bin_start;
        logic               top_pressed;
        logic               bottom_pressed;
        logic signed [15:0] encoder_count;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] lift_drive;
        logic               encoder_clear;
        logic               forklift_open_pulse;
        hugger_t            hugger_cmd;
        logic               forklift_is_open;
        logic               stack_active;
        logic [1:0]         stack_phase;
        logic               bin_active;
        logic [1:0]         bin_phase;
    } result_t;

    // true when v lies outside +/- dz
    function automatic logic beyond(input logic signed [15:0] v, input logic [14:0] dz);
        logic signed [16:0] vx;
        logic signed [16:0] pos;
        vx  = $signed({v[15], v});
        pos = $signed({2'b00, dz});
        return (vx > pos) || (vx < -pos);
    endfunction

    // limit-switch gate on a drive request
    function automatic logic signed [15:0] gate_drive(
        input logic signed [15:0] v,
        input logic [14:0]        dz,
        input logic               top,
        input logic               bot
    );
        logic signed [16:0] vx;
        logic signed [16:0] pos;
        logic               pass;
        vx  = $signed({v[15], v});
        pos = $signed({2'b00, dz});
        if (top)
            pass = vx < -pos;
        else if (bot)
            pass = vx > pos;
        else
            pass = (vx > pos) || (vx < -pos);
        return pass ? v : 16'sd0;
    endfunction

endpackage

// ----- sv/lsc_cfg.sv -----
// ---------------------------------------------------------------------------
// lsc_cfg
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module lsc_cfg
    import lsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                CFG_DRIVE_DEADZONE:      cfg_next.drive_deadzone      = cfg_data;
                CFG_BIN_DEADZONE:        cfg_next.bin_deadzone        = cfg_data;
                CFG_ENCODER_SLACK:       cfg_next.encoder_slack       = cfg_data[9:0];
                CFG_RAISE_TARGET:        cfg_next.raise_target        = cfg_data;
                CFG_FORKLIFT_OPEN_BELOW: cfg_next.forklift_open_below = cfg_data;
                CFG_BOTTOM_WINDOW:       cfg_next.bottom_window       = cfg_data[9:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drive_deadzone      <= 15'd1638;
            cfg_reg.bin_deadzone        <= 15'd1638;
            cfg_reg.encoder_slack       <= 10'd25;
            cfg_reg.raise_target        <= 15'd3275;
            cfg_reg.forklift_open_below <= 15'd2500;
            cfg_reg.bottom_window       <= 10'd20;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/lsc_core.sv -----
// ---------------------------------------------------------------------------
// lsc_core
// Sequence state and the per-tick drive, switch and step logic.
// ---------------------------------------------------------------------------
module lsc_core
    import lsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     advance,
    input  cfg_t     cfg,
    input  in_item_t item,
    output result_t  result
);

    logic               stack_run_reg, stack_run_next;
    stack_step_t        stack_step_reg, stack_step_next;
    logic               bin_run_reg, bin_run_next;
    bin_step_t          bin_step_reg, bin_step_next;
    logic               fork_reg, fork_next;
    logic signed [15:0] drive_reg, drive_next;

    logic               top;
    logic               bot;
    logic signed [15:0] man;
    logic signed [15:0] enc_eff;
    logic signed [16:0] enc_x;
    logic signed [16:0] raise_thr;
    logic signed [16:0] fork_thr;
    logic signed [16:0] win_thr;
    logic               gated;
    logic               pulse;
    hugger_t            hug;

    assign top = item.top_pressed;
    assign bot = item.bottom_pressed;
    assign man = item.manual_cmd;

    // with the bottom switch pressed and the top one not, the count seen later in the tick is zero
    assign enc_eff   = (bot && !top) ? 16'sd0 : item.encoder_count;
    assign enc_x     = $signed({enc_eff[15], enc_eff});
    assign raise_thr = $signed({2'b00, cfg.raise_target}) - $signed({7'b0, cfg.encoder_slack});
    assign fork_thr  = $signed({2'b00, cfg.forklift_open_below});
    assign win_thr   = $signed({7'b0, cfg.bottom_window});

    always_comb
    begin
        stack_run_next  = stack_run_reg;
        stack_step_next = stack_step_reg;
        bin_run_next    = bin_run_reg;
        bin_step_next   = bin_step_reg;
        fork_next       = fork_reg;
        drive_next      = drive_reg;
        gated           = 1'b0;
        pulse           = 1'b0;
        hug             = HUG_NONE;

        if (item.stack_start && !bin_run_reg)
            stack_run_next = 1'b1;
        else if (item.bin_start && !stack_run_reg)
            bin_run_next = 1'b1;

        if (stack_run_next)
        begin
            if (stack_step_next == STACK_RAISE)
            begin
                drive_next = gate_drive(Q_ONE, cfg.drive_deadzone, top, bot);
                gated      = 1'b1;
                if (enc_x > raise_thr)
                    stack_step_next = STACK_LOWER;
            end
            if (stack_step_next == STACK_LOWER)
            begin
                drive_next = gate_drive(Q_LOWER_STACK, cfg.drive_deadzone, top, bot);
                gated      = 1'b1;
                if (enc_x < fork_thr)
                begin
                    pulse     = 1'b1;
                    fork_next = 1'b1;
                end
                if (!enc_eff[15] && (enc_x < win_thr))
                begin
                    stack_step_next = STACK_DONE;
                    drive_next      = 16'sd0;
                end
            end
            if (stack_step_next == STACK_DONE)
                stack_run_next = 1'b0;
            // manual override
            if (beyond(man, cfg.drive_deadzone))
            begin
                drive_next     = gate_drive(man, cfg.drive_deadzone, top, bot);
                gated          = 1'b1;
                stack_run_next = 1'b0;
            end
        end
        else if (bin_run_next)
        begin
            if (bin_step_next == BIN_RAISE)
            begin
                hug        = HUG_OPEN;
                drive_next = gate_drive(Q_RAISE_BIN, cfg.drive_deadzone, top, bot);
                gated      = 1'b1;
                if (top)
                    bin_step_next = BIN_CLOSE;
            end
            if (bin_step_next == BIN_CLOSE)
            begin
                drive_next    = 16'sd0;
                gated         = 1'b1;
                hug           = HUG_CLOSE;
                bin_step_next = BIN_LOWER;
            end
            if (bin_step_next == BIN_LOWER)
            begin
                drive_next = gate_drive(Q_LOWER_BIN, cfg.drive_deadzone, top, bot);
                gated      = 1'b1;
                if (bot)
                    bin_step_next = BIN_DONE;
            end
            if (bin_step_next == BIN_DONE)
                bin_run_next = 1'b0;
            if (beyond(man, cfg.bin_deadzone))
                bin_run_next = 1'b0;
        end
        else
        begin
            drive_next      = gate_drive(man, cfg.drive_deadzone, top, bot);
            gated           = 1'b1;
            stack_step_next = STACK_RAISE;
            bin_step_next   = BIN_RAISE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stack_run_reg  <= 1'b0;
            stack_step_reg <= STACK_RAISE;
            bin_run_reg    <= 1'b0;
            bin_step_reg   <= BIN_RAISE;
            fork_reg       <= 1'b0;
            drive_reg      <= 16'sd0;
        end
        else if (advance)
        begin
            stack_run_reg  <= stack_run_next;
            stack_step_reg <= stack_step_next;
            bin_run_reg    <= bin_run_next;
            bin_step_reg   <= bin_step_next;
            fork_reg       <= fork_next;
            drive_reg      <= drive_next;
        end
    end

    always_comb
    begin
        result.lift_drive          = drive_next;
        result.encoder_clear       = gated && bot && !top;
        result.forklift_open_pulse = pulse;
        result.hugger_cmd          = hug;
        result.forklift_is_open    = fork_next;
        result.stack_active        = stack_run_next;
        result.stack_phase         = stack_step_next;
        result.bin_active          = bin_run_next;
        result.bin_phase           = bin_step_next;
    end

endmodule

// ----- sv/lift_sequence_controller.sv -----
// ---------------------------------------------------------------------------
// lift_sequence_controller
// Lift drive gate with stack and bin sequences, one result word per tick.
// ---------------------------------------------------------------------------
// usage:
//   s_* carries one control tick per word (manual command, start requests,
//   limit switches, encoder count). m_* returns one result word per tick
//   (lift drive, encoder clear, forklift and hugger commands, sequence state).
//   cfg_we/cfg_addr/cfg_data write the six setup registers; write them only
//   while no tick is in flight.
// path: a word accepted on s_* passes the input register, then the result
//   register, and is presented on m_*.
// throughput: one word per cycle when not stalled; the tick logic is a single
//   compare and select pass between the two registers, and the sequence
//   state updates once per word as it moves into the result register.
// reset: both registers empty, both sequences idle at their first step,
//   forklift flag and held drive cleared, setup registers at their defaults.
// stall: while m_tready is low the result word holds; the input register
//   still takes one more word, then s_tready drops until the result drains.
// ---------------------------------------------------------------------------
module lift_sequence_controller
    import lsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // manual_cmd[15:0], stack_start[16], bin_start[17], top_pressed[18],
    // bottom_pressed[19], encoder_count[35:20], zero pad[39:36]
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // lift_drive[15:0], encoder_clear[16], forklift_open_pulse[17],
    // hugger_cmd[19:18], forklift_is_open[20], stack_active[21],
    // stack_phase[23:22], bin_active[24], bin_phase[26:25], zero pad[31:27]
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg;
    in_item_t in_data_reg, in_data_next;
    logic     in_valid_reg, in_valid_next;
    result_t  out_data_reg, out_data_next;
    logic     out_valid_reg, out_valid_next;
    result_t  result;
    logic     advance;
    logic     s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    lsc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    lsc_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .cfg     (cfg),
        .item    (in_data_reg),
        .result  (result)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_data_next  = in_data_reg;
        if (s_fire)
        begin
            in_valid_next               = 1'b1;
            in_data_next.manual_cmd     = $signed(s_tdata[15:0]);
            in_data_next.stack_start    = s_tdata[16];
            in_data_next.bin_start      = s_tdata[17];
            in_data_next.top_pressed    = s_tdata[18];
            in_data_next.bottom_pressed = s_tdata[19];
            in_data_next.encoder_count  = $signed(s_tdata[35:20]);
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_data_next  = result;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        in_data_reg  <= in_data_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0,
                       out_data_reg.bin_phase,
                       out_data_reg.bin_active,
                       out_data_reg.stack_phase,
                       out_data_reg.stack_active,
                       out_data_reg.forklift_is_open,
                       out_data_reg.hugger_cmd,
                       out_data_reg.forklift_open_pulse,
                       out_data_reg.encoder_clear,
                       out_data_reg.lift_drive};

endmodule

// ----- sv/lsc_checker.sv -----
// ---------------------------------------------------------------------------
// lsc_checker
// Port-level checks of the lift sequence controller, bound to the top level.
// ---------------------------------------------------------------------------
module lsc_checker
    import lsc_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // the two sequences never run together
    a_one_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[21] && m_tdata[24]))
        else $error("stack and bin sequences both active");

    // clearing the encoder means the bottom gate ran, so drive is never downward
    a_clr_up: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[16] |-> !m_tdata[15])
        else $error("downward drive with encoder clear");

    // hugger code and pad bits stay legal
    a_fmt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[19:18] != 2'b11) && (m_tdata[31:27] == 5'b0))
        else $error("bad hugger code or pad bits");

endmodule

bind lift_sequence_controller lsc_checker u_lsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
